// ----- hdl/dop_pkg.sv -----
package dop_pkg;

  localparam int FracBits    = 16;
  localparam int CordicSteps = FracBits + 2;

  // Exponent path: five set-up stages, two per Horner term and a rounding stage.
  localparam int HornerTerms = 10;
  localparam int ExpLatency  = 5 + 2 * HornerTerms + 1;
  // The cosine path is padded out to the exponent path.
  localparam int CosPad      = ExpLatency - (CordicSteps + 1);

  localparam logic [31:0] KinvQ30  = 32'd652032874;
  localparam logic [31:0] KpiQ32   = 32'd1732062372;
  localparam logic [31:0] KexpQ32  = 32'd216507979;
  localparam logic [31:0] Invln2Q26 = 32'd96817625;
  localparam logic [31:0] Ln2Q32   = 32'd2977044472;
  localparam logic [16:0] OneQ16   = 17'd65536;

  typedef enum logic [1:0] {
    REG_MASS  = 2'd0,
    REG_MIXE  = 2'd1,
    REG_MIXMU = 2'd2,
    REG_COUP  = 2'd3
  } reg_idx_e;

  function automatic logic signed [33:0] cordic_turn(input int i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sd536870912;  1: r = 34'sd316933406;  2: r = 34'sd167458907;
      3: r = 34'sd85004756;   4: r = 34'sd42667331;   5: r = 34'sd21354465;
      6: r = 34'sd10679838;   7: r = 34'sd5340245;    8: r = 34'sd2670163;
      9: r = 34'sd1335087;    10: r = 34'sd667544;    11: r = 34'sd333772;
      12: r = 34'sd166886;    13: r = 34'sd83443;     14: r = 34'sd41722;
      15: r = 34'sd20861;     16: r = 34'sd10430;     17: r = 34'sd5215;
      18: r = 34'sd2608;      19: r = 34'sd1304;      20: r = 34'sd652;
      21: r = 34'sd326;       22: r = 34'sd163;       23: r = 34'sd81;
      24: r = 34'sd41;        25: r = 34'sd20;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

// ----- hdl/dop_cordic.sv -----
// Pipelined rotation-mode CORDIC: one iteration per stage, one item per cycle.
module dop_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic [31:0]        turn_i,
  output logic               vld_o,
  output logic signed [17:0] cos_o
);

  localparam int N = dop_pkg::CordicSteps;

  logic               v_q   [N+1];
  logic signed [33:0] x_q   [N+1];
  logic signed [33:0] y_q   [N+1];
  logic signed [33:0] z_q   [N+1];
  logic               neg_q [N+1];

  logic [32:0] t1;
  logic [32:0] t2;
  logic        neg0;

  always_comb begin
    t1 = {1'b0, turn_i};
    if (turn_i[31]) t1 = 33'h1_0000_0000 - {1'b0, turn_i};
    neg0 = 1'b0;
    t2 = t1;
    if (t1 > 33'h0_4000_0000) begin
      t2 = 33'h0_8000_0000 - t1;
      neg0 = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else begin
      v_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q[0]   <= {2'b0, dop_pkg::KinvQ30};
    y_q[0]   <= '0;
    z_q[0]   <= {1'b0, t2};
    neg_q[0] <= neg0;
  end

  for (genvar i = 0; i < N; i++) begin : g_it
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else begin
        v_q[i+1] <= v_q[i];
      end
    end
    always_ff @(posedge clk_i) begin
      neg_q[i+1] <= neg_q[i];
      if (!z_q[i][33]) begin
        x_q[i+1] <= x_q[i] - (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] + (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] - dop_pkg::cordic_turn(i);
      end else begin
        x_q[i+1] <= x_q[i] + (y_q[i] >>> i);
        y_q[i+1] <= y_q[i] - (x_q[i] >>> i);
        z_q[i+1] <= z_q[i] + dop_pkg::cordic_turn(i);
      end
    end
  end

  logic signed [33:0] c_w;
  logic signed [17:0] c_sat;
  logic signed [17:0] cos_w;
  localparam logic signed [33:0] Half = 34'sd1 <<< (29 - dop_pkg::FracBits);
  localparam logic signed [33:0] One  = 34'sd1 <<< dop_pkg::FracBits;

  always_comb begin
    c_w = (x_q[N] + Half) >>> (30 - dop_pkg::FracBits);
    if (c_w > One) c_w = One;
    if (c_w < -One) c_w = -One;
    c_sat = c_w[17:0];
    cos_w = neg_q[N] ? -c_sat : c_sat;
  end

  // Delay to match the exponent pipeline.
  localparam int Pad = dop_pkg::CosPad;
  logic signed [17:0] cd_q [Pad+1];
  logic               vd_q [Pad+1];
  assign cd_q[0] = cos_w;
  assign vd_q[0] = v_q[N];
  for (genvar j = 0; j < Pad; j++) begin : g_pad
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vd_q[j+1] <= 1'b0;
      end else begin
        vd_q[j+1] <= vd_q[j];
      end
    end
    always_ff @(posedge clk_i) cd_q[j+1] <= cd_q[j];
  end

  assign cos_o = cd_q[Pad];
  assign vld_o = vd_q[Pad];

endmodule

// ----- hdl/dop_exp.sv -----
// exp(-y) pipeline: y from g2*P, then range reduction and a Horner series
// with two stages per term. The cosine path is padded to match the
// exponent path.
module dop_exp (
  input  logic        clk_i,
  input  logic [55:0] p_i,
  input  logic [19:0] coup_i,
  output logic [16:0] e_o
);

  // Stage 1: a = g2*KEXP (52 bits).
  logic [55:0] p1_q;
  logic [51:0] a1_q;
  always_ff @(posedge clk_i) begin
    p1_q <= p_i;
    a1_q <= 52'(coup_i) * 52'(dop_pkg::KexpQ32);
  end

  // Stage 2: partial products of a*p split at 32 bits. Sum needs bits 48..
  logic [63:0] pp00_q, pp01_q, pp10_q, pp11_q;
  always_ff @(posedge clk_i) begin
    pp00_q <= 64'(a1_q[31:0]) * 64'(p1_q[31:0]);
    pp01_q <= 64'(a1_q[31:0]) * 64'(p1_q[55:32]);
    pp10_q <= 64'(a1_q[51:32]) * 64'(p1_q[31:0]);
    pp11_q <= 64'(a1_q[51:32]) * 64'(p1_q[55:32]);
  end

  // Stage 3: y = (a*p) >> 48, saturated to 2^37-1.
  logic [111:0] prod;
  logic [36:0]  y3_q;
  always_comb begin
    prod = 112'(pp00_q) + (112'(pp01_q) << 32) + (112'(pp10_q) << 32)
         + (112'(pp11_q) << 64);
  end
  always_ff @(posedge clk_i) begin
    if (|prod[111:85]) y3_q <= '1;
    else               y3_q <= prod[84:48];
  end

  // Stage 4: w = y*INVLN2 >> 26.
  logic [68:0] wp;
  logic [5:0]  n4_q;
  logic [31:0] f4_q;
  always_comb wp = 69'(y3_q) * 69'(dop_pkg::Invln2Q26);
  always_ff @(posedge clk_i) begin
    n4_q <= wp[63:58];
    f4_q <= wp[57:26];
  end

  // Stage 5: g = f*LN2 >> 32.
  logic [63:0] gp;
  logic [31:0] g5_q;
  logic [5:0]  n5_q;
  always_comb gp = 64'(f4_q) * 64'(dop_pkg::Ln2Q32);
  always_ff @(posedge clk_i) begin
    g5_q <= gp[63:32];
    n5_q <= n4_q;
  end

  // Horner terms k = 10 .. 1: the product in one stage, then the division
  // by k as a shift or a reciprocal multiplication in the next.
  logic [32:0] s_q [11];
  logic [31:0] g_q [11];
  logic [5:0]  n_q [11];
  assign s_q[0] = 33'h1_0000_0000;
  assign g_q[0] = g5_q;
  assign n_q[0] = n5_q;

  for (genvar j = 0; j < 10; j++) begin : g_hor
    localparam int K = 10 - j;
    logic [63:0] m;
    logic [31:0] d_q;
    logic [31:0] gd_q;
    logic [5:0]  nd_q;
    logic [31:0] q;
    always_comb m = 64'(g_q[j]) * 64'(s_q[j]);
    always_ff @(posedge clk_i) begin
      d_q  <= m[63:32];
      gd_q <= g_q[j];
      nd_q <= n_q[j];
    end
    if ((K & (K - 1)) == 0) begin : g_shift
      assign q = d_q >> $clog2(K);
    end else begin : g_recip
      // ceil(2^36/k) is exact for every 32-bit dividend when k is at most ten.
      localparam logic [34:0] Recip = 35'(((64'd1 << 36) + 64'(K - 1)) / 64'(K));
      logic [66:0] qp;
      assign qp = 67'(d_q) * 67'(Recip);
      assign q  = {1'b0, qp[66:36]};
    end
    always_ff @(posedge clk_i) begin
      s_q[j+1] <= 33'h1_0000_0000 - {1'b0, q};
      g_q[j+1] <= gd_q;
      n_q[j+1] <= nd_q;
    end
  end

  // Final shift and round.
  localparam int Base = 32 - dop_pkg::FracBits;
  logic [6:0]  sh;
  logic [33:0] rs;
  logic [16:0] e_d;
  logic [16:0] e_q;
  always_comb begin
    sh  = 7'(Base) + 7'(n_q[10]);
    e_d = '0;
    if (sh <= 7'd33) begin
      rs  = ({1'b0, s_q[10]} + (34'd1 << (sh - 7'd1))) >> sh;
      e_d = rs[16:0];
    end else begin
      rs = '0;
    end
  end
  always_ff @(posedge clk_i) e_q <= e_d;

  assign e_o = e_q;

endmodule

// ----- hdl/dop_combine.sv -----
// Combines E and cos into the three probabilities over three stages.
module dop_combine (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               vld_i,
  input  logic signed [17:0] cos_i,
  input  logic [16:0]        e_i,
  input  logic [16:0]        ue_i,
  input  logic [16:0]        um_i,
  output logic               vld_o,
  output logic [16:0]        p_mumu_o,
  output logic [16:0]        p_mue_o,
  output logic [16:0]        p_ee_o,
  output logic               oor_o
);

  localparam int F = dop_pkg::FracBits;
  localparam logic signed [39:0] HalfF = 40'sd1 <<< (F - 1);

  logic [2:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q <= '0;
    else         v_q <= {v_q[1:0], vld_i};
  end

  // Stage A: EC and EE.
  logic signed [39:0] ecp, eep;
  logic signed [19:0] ec_q, ee_q;
  logic [16:0]        ue_a_q, um_a_q;
  always_comb begin
    ecp = 40'(signed'({1'b0, e_i})) * 40'(cos_i);
    eep = 40'(signed'({1'b0, e_i})) * 40'(signed'({1'b0, e_i}));
  end
  always_ff @(posedge clk_i) begin
    ec_q   <= 20'((ecp + HalfF) >>> F);
    ee_q   <= 20'((eep + HalfF) >>> F);
    ue_a_q <= (ue_i > dop_pkg::OneQ16) ? dop_pkg::OneQ16 : ue_i;
    um_a_q <= (um_i > dop_pkg::OneQ16) ? dop_pkg::OneQ16 : um_i;
  end

  // Stage B: mixing products.
  logic signed [21:0] osc, om;
  logic signed [41:0] tm_q, te_q, osc_mm_q, osc_ee_q, osc_em_q;
  logic signed [21:0] osc_q;
  always_comb begin
    osc = 22'(1 <<< F) - 22'(2 * 22'(ec_q)) + 22'(ee_q);
    om  = 22'(1 <<< F) - 22'(ec_q);
  end
  always_ff @(posedge clk_i) begin
    tm_q     <= 42'(signed'({1'b0, um_a_q})) * 42'(om);
    te_q     <= 42'(signed'({1'b0, ue_a_q})) * 42'(om);
    osc_mm_q <= 42'(signed'({1'b0, um_a_q})) * 42'(signed'({1'b0, um_a_q}));
    osc_ee_q <= 42'(signed'({1'b0, ue_a_q})) * 42'(signed'({1'b0, ue_a_q}));
    osc_em_q <= 42'(signed'({1'b0, ue_a_q})) * 42'(signed'({1'b0, um_a_q}));
    osc_q    <= osc;
  end

  // Stage C: raw values in Q.(32+F), finish and clamp.
  localparam logic signed [63:0] OneHi = 64'sd1 <<< (32 + F);
  localparam logic signed [63:0] Tol   = (64'sd1 <<< (12 + F)) + (64'sd1 <<< 34);
  logic signed [63:0] r_mm, r_me, r_ee;

  function automatic logic [16:0] fin(input logic signed [63:0] r);
    logic signed [63:0] t;
    t = (r + (64'sd1 <<< (15 + F))) >>> (16 + F);
    if (r <= 0) return '0;
    if (t > 64'sd65536) return dop_pkg::OneQ16;
    return t[16:0];
  endfunction

  function automatic logic bad(input logic signed [63:0] r);
    return (r < -Tol) || (r > OneHi + Tol);
  endfunction

  always_comb begin
    r_mm = OneHi - 64'(tm_q) * 64'sd131072 + 64'(osc_mm_q) * 64'(osc_q);
    r_me = 64'(osc_em_q) * 64'(osc_q);
    r_ee = OneHi - 64'(te_q) * 64'sd131072 + 64'(osc_ee_q) * 64'(osc_q);
  end

  always_ff @(posedge clk_i) begin
    p_mumu_o <= fin(r_mm);
    p_mue_o  <= fin(r_me);
    p_ee_o   <= fin(r_ee);
    oor_o    <= bad(r_mm) | bad(r_me) | bad(r_ee);
  end

  assign vld_o = v_q[2];

endmodule

// ----- hdl/decay_oscillation_probability.sv -----
// Stages from the edge that accepts start to the edge that takes the done_o
// beat: three input stages, 19 CORDIC stages, seven padding stages to meet
// the exponent path, three combining stages.
// Throughput: one item per clock; busy is never raised.
// Reset (asynchronous, active low) clears all valid bits and loads the
// register defaults. The receiver cannot stall; done_o lasts one cycle.
module decay_oscillation_probability (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] le_ratio_i,
  output logic        done_o,
  output logic [16:0] p_mumu_o,
  output logic [16:0] p_mue_o,
  output logic [16:0] p_ee_o,
  output logic        out_of_range_o
);

  logic [23:0] mass_q;
  logic [16:0] mixe_q, mixmu_q;
  logic [19:0] coup_q;
  dop_pkg::reg_idx_e idx;

  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign idx    = dop_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mass_q  <= 24'd655;
      mixe_q  <= '0;
      mixmu_q <= '0;
      coup_q  <= '0;
    end else if (psel && penable && pwrite) begin
      case (idx)
        dop_pkg::REG_MASS:  mass_q  <= pwdata[23:0];
        dop_pkg::REG_MIXE:  mixe_q  <= pwdata[16:0];
        dop_pkg::REG_MIXMU: mixmu_q <= pwdata[16:0];
        dop_pkg::REG_COUP:  coup_q  <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dop_pkg::REG_MASS:  prdata = 32'(mass_q);
      dop_pkg::REG_MIXE:  prdata = 32'(mixe_q);
      dop_pkg::REG_MIXMU: prdata = 32'(mixmu_q);
      dop_pkg::REG_COUP:  prdata = 32'(coup_q);
      default:            prdata = '0;
    endcase
  end

  // Stage 0: P = dm2*LE.
  logic        v0_q, v1_q, v2_q;
  logic [55:0] p0_q, p1_q, p2_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v0_q <= start;
      v1_q <= v0_q;
      v2_q <= v1_q;
    end
  end
  always_ff @(posedge clk_i) p0_q <= 56'(mass_q) * 56'(le_ratio_i);

  // Stage 1: the phase in turns is bits 63..32 of P*KPI. Only the low word
  // of the upper partial product reaches those bits.
  logic [63:0] phl;
  logic [31:0] phh;
  logic [31:0] phl_q, phh_q;
  always_comb begin
    phl = 64'(p0_q[31:0]) * 64'(dop_pkg::KpiQ32);
    phh = 32'(64'(p0_q[55:32]) * 64'(dop_pkg::KpiQ32));
  end
  always_ff @(posedge clk_i) begin
    phl_q <= phl[63:32];
    phh_q <= phh;
    p1_q  <= p0_q;
  end

  // Stage 2: the sum wraps modulo one turn.
  logic [31:0] turn_q;
  always_ff @(posedge clk_i) begin
    turn_q <= phl_q + phh_q;
    p2_q   <= p1_q;
  end

  logic               vc;
  logic signed [17:0] cosv;
  logic [16:0]        ev;

  dop_cordic u_cordic (
    .clk_i, .rst_ni, .vld_i(v2_q), .turn_i(turn_q), .vld_o(vc), .cos_o(cosv)
  );

  dop_exp u_exp (
    .clk_i, .p_i(p2_q), .coup_i(coup_q), .e_o(ev)
  );

  dop_combine u_comb (
    .clk_i, .rst_ni, .vld_i(vc), .cos_i(cosv), .e_i(ev),
    .ue_i(mixe_q), .um_i(mixmu_q), .vld_o(done_o),
    .p_mumu_o, .p_mue_o, .p_ee_o, .oor_o(out_of_range_o)
  );

endmodule

// ----- tb/decay_oscillation_probability_test.sv -----
`timescale 1ns / 1ps

module decay_oscillation_probability_test;

  typedef struct packed {
    logic [16:0] p_mumu;
    logic [16:0] p_mue;
    logic [16:0] p_ee;
    logic        out_of_range;
  } prob_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] le_ratio_i = '0;
  logic        done_o;
  logic [16:0] p_mumu_o, p_mue_o, p_ee_o;
  logic        out_of_range_o;

  decay_oscillation_probability DUT (.*);

  always #1 clk_i = ~clk_i;

  // Local copy of the configuration registers.
  logic [23:0] cfg_dm2 = 24'd655;
  logic [16:0] cfg_mix_e = '0;
  logic [16:0] cfg_mix_mu = '0;
  logic [19:0] cfg_coup = '0;

  logic [31:0] le_pending[$];
  prob_t       prob_expected[$];
  int          mismatches = 0;
  int          gap = 0;

  logic [31:0] le_dir_a [5] = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h0001_0000,
                                32'h8000_0000};
  logic [31:0] le_dir_b [10] = '{32'd0, 32'd1, 32'h0000_FFFF, 32'h0001_0000,
                                 32'h0010_0000, 32'h5555_5555, 32'hAAAA_AAAA,
                                 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // cos(2*pi*t) with t in turns (Q0.32), returned in Q.16.
  function automatic longint cos_turns_q(input logic [31:0] t);
    logic [32:0] u;
    bit          neg;
    longint      x, y, z, dx, dy, c;
    u = {1'b0, t};
    neg = 1'b0;
    if (u >= 33'h080000000) u = 33'h100000000 - u;
    if (u > 33'h040000000) begin
      u = 33'h080000000 - u;
      neg = 1'b1;
    end
    x = longint'(dop_pkg::KinvQ30);
    y = 0;
    z = longint'(u);
    for (int i = 0; i < dop_pkg::CordicSteps; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(dop_pkg::cordic_turn(i));
      end else begin
        x += dx; y -= dy; z += longint'(dop_pkg::cordic_turn(i));
      end
    end
    c = (x + (longint'(1) << 13)) >>> 14;
    if (c > 65536) c = 65536;
    if (c < -65536) c = -65536;
    return neg ? -c : c;
  endfunction

  // exp(-y), y in Q.32, returned in Q.16.
  function automatic longint decay_factor(input logic [63:0] y);
    logic [63:0] w, n, f, g, s, sh;
    w = (y * 64'(dop_pkg::Invln2Q26)) >> 26;
    n = w >> 32;
    f = w & 64'hFFFF_FFFF;
    g = (f * 64'(dop_pkg::Ln2Q32)) >> 32;
    s = 64'h1_0000_0000;
    for (int k = 10; k >= 1; k--) s = 64'h1_0000_0000 - ((g * s) >> 32) / 64'(k);
    sh = 16 + n;
    if (sh > 33) return 0;
    return longint'((s + (64'd1 << (sh - 1))) >> sh);
  endfunction

  function automatic logic [16:0] to_prob(input longint raw, inout bit flag);
    longint tol, one_hi, r;
    tol = (longint'(1) << 28) + (longint'(1) << 34);
    one_hi = longint'(1) << 48;
    if (raw < -tol || raw > one_hi + tol) flag = 1'b1;
    if (raw <= 0) return '0;
    r = (raw + (longint'(1) << 31)) >>> 32;
    return r > 65536 ? 17'd65536 : 17'(r);
  endfunction

  function automatic prob_t predict_probs(input logic [31:0] le);
    logic [63:0]  p, phase, a, y;
    logic [127:0] full;
    longint       c, e, ec, ee, osc, om, one_hi, um, ue;
    bit           flag;
    prob_t        r;
    flag = 1'b0;
    p = 64'(cfg_dm2) * 64'(le);
    phase = p * 64'(dop_pkg::KpiQ32);
    c = cos_turns_q(phase[63:32]);
    a = 64'(cfg_coup) * 64'(dop_pkg::KexpQ32);
    full = 128'(a) * 128'(p);
    y = (full[127:85] != 0) ? 64'h1F_FFFF_FFFF : 64'(full[100:48]);
    if (y > 64'h1F_FFFF_FFFF) y = 64'h1F_FFFF_FFFF;
    e = decay_factor(y);
    ec = (e * c + 32768) >>> 16;
    ee = (e * e + 32768) >>> 16;
    osc = 65536 - 2 * ec + ee;
    om = 65536 - ec;
    one_hi = longint'(1) << 48;
    um = cfg_mix_mu > 65536 ? 65536 : longint'(cfg_mix_mu);
    ue = cfg_mix_e > 65536 ? 65536 : longint'(cfg_mix_e);
    r.p_mumu = to_prob(one_hi - 2 * um * om * 65536 + um * um * osc, flag);
    r.p_mue  = to_prob(ue * um * osc, flag);
    r.p_ee   = to_prob(one_hi - 2 * ue * om * 65536 + ue * ue * osc, flag);
    r.out_of_range = flag;
    return r;
  endfunction

  // Driver: one beat per accepted start, with random gaps.
  always @(negedge clk_i) begin
    if (!(start && busy)) begin
      if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (le_pending.size() > 0) begin
        start <= 1'b1;
        le_ratio_i <= le_pending.pop_front();
        case ($urandom_range(0, 19))
          0:        gap <= $urandom_range(20, 60);
          1, 2, 3:  gap <= $urandom_range(1, 4);
          4, 5:     gap <= 1;
          default:  gap <= 0;
        endcase
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: predict on acceptance, check on done.
  always @(posedge clk_i) begin
    prob_t want;
    if (rst_ni && start && !busy)
      prob_expected = {prob_expected, predict_probs(le_ratio_i)};
    if (rst_ni && done_o) begin
      if (prob_expected.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        want = prob_expected.pop_front();
        if (p_mumu_o !== want.p_mumu)
          report($sformatf("p_mumu %0d, expected %0d", p_mumu_o, want.p_mumu));
        if (p_mue_o !== want.p_mue)
          report($sformatf("p_mue %0d, expected %0d", p_mue_o, want.p_mue));
        if (p_ee_o !== want.p_ee)
          report($sformatf("p_ee %0d, expected %0d", p_ee_o, want.p_ee));
        if (out_of_range_o !== want.out_of_range)
          report($sformatf("out_of_range %0b, expected %0b", out_of_range_o,
                           want.out_of_range));
      end
    end
  end

  task automatic write_reg(input dop_pkg::reg_idx_e idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      dop_pkg::REG_MASS:  cfg_dm2 = val[23:0];
      dop_pkg::REG_MIXE:  cfg_mix_e = val[16:0];
      dop_pkg::REG_MIXMU: cfg_mix_mu = val[16:0];
      dop_pkg::REG_COUP:  cfg_coup = val[19:0];
      default: ;
    endcase
  endtask

  task automatic wait_drained();
    while (le_pending.size() > 0 || start || prob_expected.size() > 0) @(negedge clk_i);
    repeat (32) @(negedge clk_i);
  endtask

  task automatic set_config(input logic [31:0] dm2, mixe, mixmu, coup);
    write_reg(dop_pkg::REG_MASS, dm2);
    write_reg(dop_pkg::REG_MIXE, mixe);
    write_reg(dop_pkg::REG_MIXMU, mixmu);
    write_reg(dop_pkg::REG_COUP, coup);
  endtask

  function automatic logic [31:0] random_le();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return $urandom_range(0, 32'h000F_FFFF);
      2:       return $urandom() >> $urandom_range(0, 31);
      default: return $urandom_range(0, 32'h0100_0000);
    endcase
  endfunction

  function automatic logic [31:0] random_mix();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'd65536;
      2:       return $urandom_range(65537, 131071);
      default: return $urandom_range(0, 65536);
    endcase
  endfunction

  initial begin
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed beats at reset defaults, then with strong mixing and coupling, at full scale, and at zero mass.
    foreach (le_dir_a[i]) le_pending = {le_pending, le_dir_a[i]};
    wait_drained();
    set_config(32'd2_000_000, 32'd65536, 32'd131071, 32'd655360);
    foreach (le_dir_b[i]) le_pending = {le_pending, le_dir_b[i]};
    wait_drained();
    set_config(32'hFF_FFFF, 32'd131071, 32'd65536, 32'hF_FFFF);
    for (int i = 0; i < 6; i++)
      le_pending = {le_pending, 32'($urandom_range(0, 4096) << i)};
    wait_drained();
    set_config(32'd0, 32'd32768, 32'd32768, 32'd0);
    le_pending = {le_pending, 32'hFFFF_FFFF};
    le_pending = {le_pending, 32'h1234_5678};
    wait_drained();

    // Random phases; each ends with the sender holding off until drained.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       set_config(32'd0, 32'd65536, 32'd65536, 32'hF_FFFF);
        1:       set_config(32'hFF_FFFF, 32'd0, 32'd0, 32'd0);
        2:       set_config(32'd655, 32'd65536, 32'd65536, 32'd655360);
        default: set_config($urandom_range(0, 32'hFF_FFFF), random_mix(), random_mix(),
                            $urandom_range(0, 32'hF_FFFF));
      endcase
      for (int i = 0; i < 130; i++) le_pending = {le_pending, random_le()};
      wait_drained();
    end

    if (mismatches == 0) $display("decay_oscillation_probability test passed");
    else $display("decay_oscillation_probability test failed");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("decay_oscillation_probability test failed");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/dop_pkg.sv
hdl/dop_cordic.sv
hdl/dop_exp.sv
hdl/dop_combine.sv
hdl/decay_oscillation_probability.sv
tb/decay_oscillation_probability_test.sv
